FILE: hw/rtl/gwmr_pkg.sv
// Shared types, constants and the weight table of the Gaussian window min/max reject block.
package gwmr_pkg;

	// Field and port widths
	localparam int PIX_W      = 32;
	localparam int WGT_W      = 17;
	localparam int COORD_W    = 8;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int D2_W       = 10;
	localparam int TABLE_TOP  = 64;

	// Operation codes carried in tuser of the input stream
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_VALUE   = 3'd4;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CENTER,
		ST_SCAN,
		ST_DRAIN,
		ST_REM_MIN,
		ST_REM_MAX,
		ST_SETTLE,
		ST_DIVIDE,
		ST_WAIT_DIV,
		ST_FINISH
	} state_t;

	// What the store read issued in the previous cycle returns
	typedef enum logic [1:0] {
		K_NONE,
		K_CENTRE,
		K_NEIGH
	} kind_t;

	// What the accumulator does with the registered product
	typedef enum logic [1:0] {
		P_NONE,
		P_ADD,
		P_SUB
	} acc_op_t;

	// round(65536 * exp(-d2/8)) for d2 = 0..64
	localparam logic [WGT_W-1:0] WTAB [0:TABLE_TOP] = '{
		17'd65536, 17'd57835, 17'd51039, 17'd45042, 17'd39750, 17'd35079, 17'd30957, 17'd27319,
		17'd24109, 17'd21276, 17'd18776, 17'd16570, 17'd14623, 17'd12905, 17'd11388, 17'd10050,
		17'd8869,  17'd7827,  17'd6907,  17'd6096,  17'd5380,  17'd4747,  17'd4190,  17'd3697,
		17'd3263,  17'd2879,  17'd2541,  17'd2243,  17'd1979,  17'd1746,  17'd1541,  17'd1360,
		17'd1200,  17'd1059,  17'd935,   17'd825,   17'd728,   17'd642,   17'd567,   17'd500,
		17'd442,   17'd390,   17'd344,   17'd303,   17'd268,   17'd236,   17'd209,   17'd184,
		17'd162,   17'd143,   17'd127,   17'd112,   17'd99,    17'd87,    17'd77,    17'd68,
		17'd60,    17'd53,    17'd47,    17'd41,    17'd36,    17'd32,    17'd28,    17'd25,
		17'd22
	};

	// Weight lookup; squared distances past the table get no weight
	function automatic logic [WGT_W-1:0] weight_of(input logic [6:0] d2);
		logic [WGT_W-1:0] w;
		w = '0;
		if (int'(d2) <= TABLE_TOP) begin
			w = WTAB[d2];
		end
		return w;
	endfunction

endpackage

FILE: hw/rtl/gwmr_div.sv
// Restoring divider, one quotient bit per cycle, signed dividend over positive divisor.
module gwmr_div #(
	parameter int NW = 58,
	parameter int DW = 26
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] dividend,
	input  logic        [DW-1:0] divisor,
	output logic                 done,
	output logic signed [NW-1:0] quotient
);

	localparam int CNT_W = $clog2(NW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    quo_q;
	logic [DW:0]      rem_q;
	logic [DW-1:0]    div_q;
	logic             neg_q;
	logic [DW:0]      rem_sh;
	logic [DW:0]      rem_diff;
	logic             fits;

	// One trial subtraction per cycle
	always_comb begin
		rem_sh   = {rem_q[DW-1:0], quo_q[NW-1]};
		fits     = rem_sh >= {1'b0, div_q};
		rem_diff = rem_sh - {1'b0, div_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Magnitude shift register and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[NW-1];
			quo_q <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? rem_diff : rem_sh;
		end
	end

	// Truncation toward zero: quotient takes the dividend's sign
	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

FILE: hw/rtl/gauss_window_minmax_reject.sv
// Load one input item per cycle; a compute item walks all (2R+1)^2 window positions, one store
// read per cycle, then removes the extremes and divides (R = MAX_RADIUS).
// One item at a time; s_axis_tready is high only while the sequencer is idle.
// arst_n clears control and configuration; the pixel store holds garbage until written.
module gauss_window_minmax_reject #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_RADIUS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gwmr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gwmr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [gwmr_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // col[7:0], row[15:8], pixel[47:16]
	input  logic [0:0]                        s_axis_tuser,  // operation[0]
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [gwmr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // value[31:0]
	output logic [0:0]                        m_axis_tuser   // no_weight[0]
);

	import gwmr_pkg::*;

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = $clog2(MAX_RADIUS) + 2;
	localparam int PW     = CW + 9;
	localparam int TERMS  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int SUM_W  = PIX_W + WGT_W + $clog2(TERMS);
	localparam int SUMW_W = WGT_W + $clog2(TERMS);
	localparam int RR     = MAX_RADIUS * MAX_RADIUS;
	localparam logic signed [CW-1:0] R_NEG = CW'(-MAX_RADIUS);
	localparam logic signed [CW-1:0] R_POS = CW'(MAX_RADIUS);

	// Configuration registers
	logic [8:0]       width_q;
	logic [8:0]       height_q;
	logic [6:0]       radius_q;
	logic             mask_en_q;
	logic [PIX_W-1:0] mask_q;

	// Sequencer
	state_t state_q, state_d;
	logic [COORD_W-1:0]    col_q, row_q;
	logic signed [CW-1:0]  dx_q, dy_q;
	kind_t                 issue_kind;
	logic [AW-1:0]         rd_addr;
	logic                  div_start;

	// Stream side
	logic               in_acc;
	logic               in_op;
	logic [COORD_W-1:0] in_col, in_row;
	logic [PIX_W-1:0]   in_pixel;
	logic               centre_out;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;

	// Window geometry
	logic [8:0]             ew, eh;
	logic [6:0]             lim_eff;
	logic signed [PW-1:0]   r_pos, c_pos;
	logic [D2_W-1:0]        d2;
	logic                   pos_ok;
	logic                   scan_last;
	logic [AW-1:0]          nb_addr, ctr_addr;

	// Store and stage 1
	logic [PIX_W-1:0]        store_mem [DEPTH];
	logic [PIX_W-1:0]        rd_data_s1;
	kind_t                   kind_s1;
	logic [WGT_W-1:0]        w_s1;
	logic signed [PIX_W-1:0] v_s1;
	logic                    nb_take;

	// Running extremes
	logic signed [PIX_W-1:0] cmin_q, cmax_q;
	logic [WGT_W-1:0]        minw_q, maxw_q;

	// Shared multiplier and stage 2
	logic signed [PIX_W-1:0]       mul_a;
	logic [WGT_W-1:0]              mul_b;
	acc_op_t                       op_d, op_s2;
	logic signed [PIX_W+WGT_W-1:0] prod_s2;
	logic [WGT_W-1:0]              w_s2;

	// Accumulators and result
	logic signed [SUM_W-1:0] sum_q;
	logic [SUMW_W-1:0]       sumw_q;
	logic                    div_done;
	logic signed [SUM_W-1:0] div_quot;
	logic [PIX_W-1:0]        res_value_q;
	logic                    res_flag_q;
	logic                    m_valid_q;
	logic [PIX_W-1:0]        m_data_q;
	logic                    m_user_q;
	logic                    out_load;

	// Input field unpacking
	assign in_op    = s_axis_tuser[0];
	assign in_col   = s_axis_tdata[7:0];
	assign in_row   = s_axis_tdata[15:8];
	assign in_pixel = s_axis_tdata[47:16];
	assign in_acc   = s_axis_tvalid && s_axis_tready;

	// Effective image size and distance limit
	always_comb begin
		ew = (int'(width_q) < MAX_WIDTH) ? width_q : 9'(MAX_WIDTH);
		eh = (int'(height_q) < MAX_HEIGHT) ? height_q : 9'(MAX_HEIGHT);
		lim_eff = radius_q;
		if (int'(lim_eff) > TABLE_TOP) begin
			lim_eff = 7'(TABLE_TOP);
		end
		if (int'(lim_eff) > RR) begin
			lim_eff = 7'(RR);
		end
	end

	assign centre_out = ({1'b0, in_col} >= ew) || ({1'b0, in_row} >= eh);
	assign wr_en      = in_acc && (in_op == OP_LOAD) &&
	                    (int'(in_col) < MAX_WIDTH) && (int'(in_row) < MAX_HEIGHT);
	assign wr_addr    = AW'(int'(in_row) * MAX_WIDTH + int'(in_col));

	// Neighbour position, validity and address
	always_comb begin
		r_pos   = $signed({{(PW-COORD_W){1'b0}}, row_q}) + PW'(dy_q);
		c_pos   = $signed({{(PW-COORD_W){1'b0}}, col_q}) + PW'(dx_q);
		d2      = D2_W'(int'(dx_q) * int'(dx_q) + int'(dy_q) * int'(dy_q));
		pos_ok  = !r_pos[PW-1] && (r_pos < $signed({{(PW-9){1'b0}}, eh})) &&
		          !c_pos[PW-1] && (c_pos < $signed({{(PW-9){1'b0}}, ew})) &&
		          (d2 <= {{(D2_W-7){1'b0}}, lim_eff});
		nb_addr   = AW'(int'(r_pos[8:0]) * MAX_WIDTH + int'(c_pos[8:0]));
		ctr_addr  = AW'(int'(row_q) * MAX_WIDTH + int'(col_q));
		scan_last = (dx_q == R_POS) && (dy_q == R_POS);
	end

	// Next state and sequencer outputs
	always_comb begin
		state_d       = state_q;
		issue_kind    = K_NONE;
		rd_addr       = ctr_addr;
		div_start     = 1'b0;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && (in_op == OP_COMPUTE)) begin
					state_d = centre_out ? ST_FINISH : ST_CENTER;
				end
			end
			ST_CENTER: begin
				issue_kind = K_CENTRE;
				state_d    = ST_SCAN;
			end
			ST_SCAN: begin
				rd_addr    = nb_addr;
				issue_kind = pos_ok ? K_NEIGH : K_NONE;
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:   state_d = ST_REM_MIN;
			ST_REM_MIN: state_d = ST_REM_MAX;
			ST_REM_MAX: state_d = ST_SETTLE;
			ST_SETTLE:  state_d = ST_DIVIDE;
			ST_DIVIDE: begin
				if (sumw_q == '0) begin
					state_d = ST_FINISH;
				end else begin
					div_start = 1'b1;
					state_d   = ST_WAIT_DIV;
				end
			end
			ST_WAIT_DIV: begin
				if (div_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!m_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 9'd256;
			height_q  <= 9'd256;
			radius_q  <= '0;
			mask_en_q <= 1'b0;
			mask_q    <= 32'h8000_0000;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q   <= cfg_data[8:0];
				REG_IMAGE_HEIGHT: height_q  <= cfg_data[8:0];
				REG_RADIUS_SQ:    radius_q  <= cfg_data[6:0];
				REG_MASK_ENABLE:  mask_en_q <= cfg_data[0];
				REG_MASK_VALUE:   mask_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Centre capture and window counters
	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_q <= in_col;
			row_q <= in_row;
		end
		if (state_q == ST_CENTER) begin
			dx_q <= R_NEG;
			dy_q <= R_NEG;
		end else if (state_q == ST_SCAN) begin
			if (dx_q == R_POS) begin
				dx_q <= R_NEG;
				dy_q <= dy_q + 1'b1;
			end else begin
				dx_q <= dx_q + 1'b1;
			end
		end
	end

	// Pixel store: one write port for loads, one registered read port for the centre and the scan
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= in_pixel;
		end
		rd_data_s1 <= store_mem[rd_addr];
		w_s1       <= weight_of(d2[6:0]);
	end

	// Stage 1: mask test and extreme tracking
	always_comb begin
		v_s1    = $signed(rd_data_s1);
		nb_take = (kind_s1 == K_NEIGH) && !(mask_en_q && (rd_data_s1 == mask_q));
	end

	always_ff @(posedge clk) begin
		if (kind_s1 == K_CENTRE) begin
			cmin_q <= v_s1;
			cmax_q <= v_s1;
			minw_q <= '0;
			maxw_q <= '0;
		end else if (nb_take) begin
			if (v_s1 < cmin_q) begin
				cmin_q <= v_s1;
				minw_q <= w_s1;
			end
			if (v_s1 > cmax_q) begin
				cmax_q <= v_s1;
				maxw_q <= w_s1;
			end
		end
	end

	// Shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_REM_MIN: begin
				mul_a = cmin_q;
				mul_b = minw_q;
				op_d  = P_SUB;
			end
			ST_REM_MAX: begin
				mul_a = cmax_q;
				mul_b = maxw_q;
				op_d  = P_SUB;
			end
			default: begin
				mul_a = v_s1;
				mul_b = w_s1;
				op_d  = nb_take ? P_ADD : P_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s1 <= K_NONE;
			op_s2   <= P_NONE;
		end else begin
			kind_s1 <= issue_kind;
			op_s2   <= op_d;
		end
	end

	// Stage 2 product register
	always_ff @(posedge clk) begin
		prod_s2 <= mul_a * $signed({1'b0, mul_b});
		w_s2    <= mul_b;
	end

	// Product and weight accumulators
	always_ff @(posedge clk) begin
		if (state_q == ST_CENTER) begin
			sum_q  <= '0;
			sumw_q <= '0;
		end else begin
			case (op_s2)
				P_ADD: begin
					sum_q  <= sum_q + SUM_W'(prod_s2);
					sumw_q <= sumw_q + SUMW_W'(w_s2);
				end
				P_SUB: begin
					sum_q  <= sum_q - SUM_W'(prod_s2);
					sumw_q <= sumw_q - SUMW_W'(w_s2);
				end
				default: ;
			endcase
		end
	end

	gwmr_div #(
		.NW(SUM_W),
		.DW(SUMW_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_q),
		.divisor (sumw_q),
		.done    (div_done),
		.quotient(div_quot)
	);

	// Result: defaults to the no-weight answer, the quotient overwrites it
	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_value_q <= '0;
			res_flag_q  <= 1'b1;
		end else if (div_done && (state_q == ST_WAIT_DIV)) begin
			res_value_q <= div_quot[PIX_W-1:0];
			res_flag_q  <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= res_value_q;
			m_user_q <= res_flag_q;
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = m_data_q;
	assign m_axis_tuser[0] = m_user_q;

	// Divider never starts on an empty weight sum
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (sumw_q != '0))
		else $error("divider started with zero weight sum");

	// Neighbour data in stage 1 only follows a scan cycle
	a_neigh_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_s1 == K_NEIGH) |-> ($past(state_q) == ST_SCAN))
		else $error("neighbour data outside of the scan");

	// Extreme removal only follows the two removal cycles
	a_sub_from_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(op_s2 == P_SUB) |-> (($past(state_q) == ST_REM_MIN) || ($past(state_q) == ST_REM_MAX)))
		else $error("subtraction outside of extreme removal");

	// A divider result is only ever awaited in its wait state
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_WAIT_DIV))
		else $error("divider finished outside of its wait state");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the Gaussian window mean with min/max rejection block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gwmr_pkg::*;

	localparam int IMG_MAX       = 256;
	localparam int RADIUS_MAX    = 8;
	localparam int WT_TOP        = 64;
	localparam int ITEM_TARGET   = 1550;
	localparam int PHASE_ITEMS   = 40;
	localparam int SETTLE_CYCLES = 400;
	localparam int HOLD_CYCLES   = 1500;
	localparam int CYCLE_LIMIT   = 8000000;

	typedef struct packed {
		logic [31:0] value;
		logic        no_weight;
	} mean_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // col[7:0], row[15:8], pixel[47:16]
	logic [0:0]            s_axis_tuser = '0;   // operation[0]
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // value[31:0]
	logic [0:0]            m_axis_tuser;        // no_weight[0]

	// Shadow of the block's configuration and pixel store
	int          cfg_width = 256;
	int          cfg_height = 256;
	int          cfg_radius_sq = 0;
	logic        cfg_mask_en = 1'b0;
	logic [31:0] cfg_mask_value = 32'h80000000;
	logic [31:0] pix_mem [0:IMG_MAX*IMG_MAX-1];
	bit          written [0:IMG_MAX*IMG_MAX-1];
	int          wt_q16 [0:WT_TOP];

	mean_t pending_means [$];
	int    err_count = 0;
	int    sent_items = 0;
	int    cycle_count = 0;
	bit    idle_on = 1'b0;
	int    stall_left = 0;
	int    hold_left = 0;

	gauss_window_minmax_reject u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Idle length: mostly short, now and then long
	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 20);
		return $urandom_range(30, 200);
	endfunction

	function automatic int eff_width();
		return (cfg_width < IMG_MAX) ? cfg_width : IMG_MAX;
	endfunction

	function automatic int eff_height();
		return (cfg_height < IMG_MAX) ? cfg_height : IMG_MAX;
	endfunction

	// Weighted mean over the window with the lowest and highest neighbour removed
	function automatic mean_t predict_mean(input int col, input int row);
		int          ew, eh, lim, dy, dx, r, c, d2;
		logic [31:0] raw;
		longint      v, w, lo, hi, lo_w, hi_w, acc, wsum, q;
		mean_t       res;
		ew = eff_width();
		eh = eff_height();
		lim = cfg_radius_sq;
		if (lim > WT_TOP) lim = WT_TOP;
		if (lim > RADIUS_MAX * RADIUS_MAX) lim = RADIUS_MAX * RADIUS_MAX;
		res.value = '0;
		res.no_weight = 1'b1;
		if (col >= ew || row >= eh) return res;
		// centre seeds both extremes with zero weight, even when masked
		lo = longint'($signed(pix_mem[row * IMG_MAX + col]));
		hi = lo;
		lo_w = 0;
		hi_w = 0;
		acc = 0;
		wsum = 0;
		for (dy = -RADIUS_MAX; dy <= RADIUS_MAX; dy++) begin
			r = row + dy;
			if (r < 0 || r >= eh) continue;
			for (dx = -RADIUS_MAX; dx <= RADIUS_MAX; dx++) begin
				c = col + dx;
				d2 = dx * dx + dy * dy;
				if (c < 0 || c >= ew || d2 > lim) continue;
				raw = pix_mem[r * IMG_MAX + c];
				if (cfg_mask_en && raw == cfg_mask_value) continue;
				v = longint'($signed(raw));
				w = longint'(wt_q16[d2]);
				// strict compares: the earliest value seen, centre included, keeps a tie
				if (v < lo) begin
					lo = v;
					lo_w = w;
				end
				if (v > hi) begin
					hi = v;
					hi_w = w;
				end
				acc += v * w;
				wsum += w;
			end
		end
		acc = acc - lo * lo_w - hi * hi_w;
		wsum = wsum - lo_w - hi_w;
		if (wsum > 0) begin
			q = acc / wsum;
			res.value = q[31:0];
			res.no_weight = 1'b0;
		end
		return res;
	endfunction

	// One register write transaction
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_IMAGE_WIDTH:  cfg_width = int'(data[8:0]);
			REG_IMAGE_HEIGHT: cfg_height = int'(data[8:0]);
			REG_RADIUS_SQ:    cfg_radius_sq = int'(data[6:0]);
			REG_MASK_ENABLE:  cfg_mask_en = data[0];
			REG_MASK_VALUE:   cfg_mask_value = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// One input transaction; shadow store and predictions follow acceptance order
	task automatic send_item(input logic op, input int col, input int row,
			input logic [31:0] pix);
		int gap;
		gap = idle_on ? idle_len() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {pix, row[7:0], col[7:0]};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		sent_items++;
		if (op == OP_LOAD) begin
			pix_mem[{row[7:0], col[7:0]}] = pix;
			written[{row[7:0], col[7:0]}] = 1'b1;
		end else begin
			pending_means.push_back(predict_mean(col, row));
		end
	endtask

	// Drop valid, wait for every result, then let the block go quiet
	task automatic settle_block();
		s_axis_tvalid <= 1'b0;
		while (pending_means.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Pixel values biased toward ties, the mask value and the extremes
	function automatic logic [31:0] pick_pixel();
		int t;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				t = $urandom_range(0, 8);
				return t - 4;
			end
			3: return cfg_mask_value;
			4: return 32'h7fffffff;
			5: return 32'h80000000;
			6: begin
				t = $urandom_range(0, 2000);
				return t - 1000;
			end
			default: return $urandom;
		endcase
	endfunction

	// Load every in-image pixel that any radius could reach before a compute
	task automatic ensure_window(input int col, input int row);
		int ew, eh, dy, dx, r, c;
		ew = eff_width();
		eh = eff_height();
		if (col >= ew || row >= eh) return;
		for (dy = -RADIUS_MAX; dy <= RADIUS_MAX; dy++) begin
			for (dx = -RADIUS_MAX; dx <= RADIUS_MAX; dx++) begin
				r = row + dy;
				c = col + dx;
				if (r >= 0 && r < eh && c >= 0 && c < ew &&
						dx * dx + dy * dy <= RADIUS_MAX * RADIUS_MAX &&
						!written[r * IMG_MAX + c])
					send_item(OP_LOAD, c, r, pick_pixel());
			end
		end
	endtask

	// Result checker and receiver-side stall generator
	always @(posedge clk) begin
		mean_t want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (pending_means.size() == 0) begin
				$display("%0t unexpected result: expected none, got value %0d no_weight %0b",
					$time, $signed(m_axis_tdata), m_axis_tuser);
				err_count++;
			end else begin
				want = pending_means.pop_front();
				if (m_axis_tdata !== want.value) begin
					$display("%0t value mismatch: expected %0d, got %0d", $time,
						$signed(want.value), $signed(m_axis_tdata));
					err_count++;
				end
				if (m_axis_tuser[0] !== want.no_weight) begin
					$display("%0t no_weight mismatch: expected %0b, got %0b", $time,
						want.no_weight, m_axis_tuser[0]);
					err_count++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (idle_on && $urandom_range(0, 3) == 0) stall_left = idle_len();
		end
	end

	// Small 4x4 image with extreme and tied values, full radius
	task automatic test_window_mean();
		logic [31:0] seed_vals [0:15];
		int          i;
		seed_vals = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff,
			32'd5, 32'd5, 32'hfffffffd, 32'd100,
			32'd5, 32'h7fffffff, 32'h80000000, 32'd2,
			32'hfffffff9, 32'h0, 32'd1, 32'd5};
		settle_block();
		idle_on = 1'b1;
		cfg_write(REG_IMAGE_WIDTH, 4);
		cfg_write(REG_IMAGE_HEIGHT, 4);
		cfg_write(REG_RADIUS_SQ, 64);
		cfg_write(REG_MASK_ENABLE, 0);
		cfg_write(REG_MASK_VALUE, 32'h80000000);
		for (i = 0; i < 16; i++) send_item(OP_LOAD, i % 4, i / 4, seed_vals[i]);
		send_item(OP_COMPUTE, 0, 0, 32'h0);
		send_item(OP_COMPUTE, 3, 3, 32'hffffffff);
		send_item(OP_COMPUTE, 1, 2, 32'h0);
	endtask

	// Centres past the image edge, and a short radius
	task automatic test_outside_image();
		send_item(OP_COMPUTE, 4, 0, 32'h0);
		send_item(OP_COMPUTE, 0, 4, 32'h0);
		send_item(OP_COMPUTE, 255, 255, 32'h0);
		settle_block();
		cfg_write(REG_RADIUS_SQ, 2);
		send_item(OP_COMPUTE, 1, 1, 32'h0);
	endtask

	// Masked neighbours skipped, a masked centre still seeds the extremes
	task automatic test_masking();
		settle_block();
		cfg_write(REG_RADIUS_SQ, 64);
		cfg_write(REG_MASK_ENABLE, 1);
		cfg_write(REG_MASK_VALUE, 5);
		send_item(OP_COMPUTE, 0, 1, 32'h0);
		send_item(OP_COMPUTE, 1, 1, 32'h0);
		settle_block();
		cfg_write(REG_MASK_VALUE, 32'h7fffffff);
		send_item(OP_COMPUTE, 1, 2, 32'h0);
	endtask

	// Zero radius: a masked centre leaves no weight at all
	task automatic test_no_weight();
		settle_block();
		cfg_write(REG_RADIUS_SQ, 0);
		cfg_write(REG_MASK_VALUE, 5);
		send_item(OP_COMPUTE, 0, 1, 32'h0);
		send_item(OP_COMPUTE, 3, 0, 32'h0);
	endtask

	// Smallest image: a single pixel
	task automatic test_single_pixel();
		settle_block();
		cfg_write(REG_IMAGE_WIDTH, 1);
		cfg_write(REG_IMAGE_HEIGHT, 1);
		cfg_write(REG_RADIUS_SQ, 64);
		cfg_write(REG_MASK_ENABLE, 0);
		send_item(OP_COMPUTE, 0, 0, 32'h0);
		send_item(OP_COMPUTE, 1, 0, 32'h0);
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering computes
	task automatic test_output_backpressure();
		int i, c, r;
		settle_block();
		idle_on = 1'b0;
		cfg_write(REG_IMAGE_WIDTH, 6);
		cfg_write(REG_IMAGE_HEIGHT, 6);
		cfg_write(REG_RADIUS_SQ, 9);
		for (i = 0; i < 6; i++) ensure_window(i, i);
		hold_left = HOLD_CYCLES;
		for (i = 0; i < 10; i++) begin
			c = $urandom_range(0, 5);
			r = $urandom_range(0, 5);
			send_item(OP_COMPUTE, c, r, $urandom);
		end
	endtask

	function automatic int pick_size(input int top);
		int p;
		p = $urandom_range(0, 9);
		if (p == 0) return 1;
		if (p < 3) return top;
		if (p < 9) return $urandom_range(2, 24);
		return $urandom_range(25, top - 1);
	endfunction

	function automatic int pick_radius();
		int p;
		p = $urandom_range(0, 7);
		if (p == 0) return 0;
		if (p == 1) return WT_TOP;
		if (p < 4) return $urandom_range(1, 8);
		return $urandom_range(0, WT_TOP);
	endfunction

	function automatic logic [31:0] pick_mask_value();
		int t;
		case ($urandom_range(0, 3))
			0, 1: begin
				t = $urandom_range(0, 8);
				return t - 4;
			end
			2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return $urandom;
		endcase
	endfunction

	// Phases of random settings, each with computes and loads around a hot region
	task automatic test_random_traffic();
		int ew, eh, hot_c, hot_r, span_c, span_r, k, col, row;
		while (sent_items < ITEM_TARGET) begin
			settle_block();
			idle_on = ($urandom_range(0, 3) != 0);
			cfg_write(REG_IMAGE_WIDTH, pick_size(IMG_MAX));
			cfg_write(REG_IMAGE_HEIGHT, pick_size(IMG_MAX));
			cfg_write(REG_RADIUS_SQ, pick_radius());
			cfg_write(REG_MASK_ENABLE, $urandom_range(0, 1));
			cfg_write(REG_MASK_VALUE, pick_mask_value());
			ew = eff_width();
			eh = eff_height();
			// large images: stay near a corner so the store fill stays small
			if (ew > 24) begin
				span_c = 4;
				hot_c = $urandom_range(0, 1) ? ew - 4 : 0;
			end else begin
				span_c = ew + 2;
				hot_c = 0;
			end
			if (eh > 24) begin
				span_r = 4;
				hot_r = $urandom_range(0, 1) ? eh - 4 : 0;
			end else begin
				span_r = eh + 2;
				hot_r = 0;
			end
			for (k = 0; k < PHASE_ITEMS && sent_items < ITEM_TARGET; k++) begin
				if ($urandom_range(0, 99) < 60) begin
					col = hot_c + $urandom_range(0, span_c - 1);
					row = hot_r + $urandom_range(0, span_r - 1);
					if (ew < IMG_MAX && $urandom_range(0, 19) == 0)
						col = $urandom_range(ew, IMG_MAX - 1);
					if (eh < IMG_MAX && $urandom_range(0, 19) == 0)
						row = $urandom_range(eh, IMG_MAX - 1);
					ensure_window(col, row);
					send_item(OP_COMPUTE, col, row, $urandom);
				end else begin
					if ($urandom_range(0, 3) == 0) begin
						col = $urandom_range(0, IMG_MAX - 1);
						row = $urandom_range(0, IMG_MAX - 1);
					end else begin
						col = hot_c + $urandom_range(0, span_c - 1);
						row = hot_r + $urandom_range(0, span_r - 1);
					end
					send_item(OP_LOAD, col, row, pick_pixel());
				end
			end
		end
	endtask

	initial begin
		wt_q16 = '{65536, 57835, 51039, 45042, 39750, 35079, 30957, 27319,
			24109, 21276, 18776, 16570, 14623, 12905, 11388, 10050,
			8869, 7827, 6907, 6096, 5380, 4747, 4190, 3697,
			3263, 2879, 2541, 2243, 1979, 1746, 1541, 1360,
			1200, 1059, 935, 825, 728, 642, 567, 500,
			442, 390, 344, 303, 268, 236, 209, 184,
			162, 143, 127, 112, 99, 87, 77, 68,
			60, 53, 47, 41, 36, 32, 28, 25,
			22};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_window_mean();
		test_outside_image();
		test_masking();
		test_no_weight();
		test_single_pixel();
		test_output_backpressure();
		test_random_traffic();
		settle_block();
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
